### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for the concurrent checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed: same-cycle implication");

// Implication in the next cycle, active during reset too.
`define ASSERT_NEXT(label, clk, a, c) \
  label: assert property (@(posedge clk) (a) |=> (c)) \
    else $error("assertion failed: next-cycle implication");

`endif

### rtl/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types and constants of the matrix to quaternion converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rmq_pkg;

  // Width of one matrix entry and one quaternion component.
  localparam int IN_W  = 18;
  localparam int OUT_W = 18;
  // Width of a difference or sum of two entries.
  localparam int D_W   = IN_W + 1;

  // Saturation limits of a component.
  localparam int OUT_MAX     = 131071;
  localparam int OUT_MIN_MAG = 131072;

  // Component that takes root/2 directly.
  typedef enum logic [1:0] {
    SLOT_X = 2'd0,
    SLOT_Y = 2'd1,
    SLOT_Z = 2'd2,
    SLOT_W = 2'd3
  } slot_t;

endpackage

### rtl/rmq_sqrt.sv
// ----------------------------------------------------------------------------
// rmq_sqrt
// Pipelined integer square root, one result bit per stage, with sideband.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rmq_sqrt #(
  parameter int RAD_W = 36,
  parameter int SB_W  = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [RAD_W-1:0]     in_rad,
  input  logic [SB_W-1:0]      in_sb,
  output logic                 out_valid,
  output logic [RAD_W/2-1:0]   out_root,
  output logic [SB_W-1:0]      out_sb
);

  localparam int RW    = RAD_W / 2;
  localparam int REM_W = RW + 3;

  logic             vld  [0:RW];
  logic [RAD_W-1:0] rad  [0:RW];
  logic [REM_W-1:0] rem  [0:RW];
  logic [RW-1:0]    root [0:RW];
  logic [SB_W-1:0]  sb   [0:RW];

  logic [RAD_W-1:0] rad_next  [1:RW];
  logic [REM_W-1:0] rem_next  [1:RW];
  logic [RW-1:0]    root_next [1:RW];

  // Stage zero is the input itself.
  assign vld[0]  = in_valid;
  assign rad[0]  = in_rad;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign sb[0]   = in_sb;

  // One digit step per stage: bring down two bits, try root*4+1.
  always_comb begin
    logic [REM_W-1:0] sh;
    logic [REM_W-1:0] trial;
    for (int s = 0; s < RW; s++) begin
      sh    = {rem[s][REM_W-3:0], rad[s][RAD_W-1 -: 2]};
      trial = {1'b0, root[s], 2'b01};
      rad_next[s+1] = {rad[s][RAD_W-3:0], 2'b00};
      if (sh >= trial) begin
        rem_next[s+1]  = sh - trial;
        root_next[s+1] = {root[s][RW-2:0], 1'b1};
      end else begin
        rem_next[s+1]  = sh;
        root_next[s+1] = {root[s][RW-2:0], 1'b0};
      end
    end
  end

  for (genvar s = 0; s < RW; s++) begin : g_stage
    // Valid bit of the stage.
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end

    // Payload of the stage.
    always_ff @(posedge clk) begin
      if (en) begin
        rad[s+1]  <= rad_next[s+1];
        rem[s+1]  <= rem_next[s+1];
        root[s+1] <= root_next[s+1];
        sb[s+1]   <= sb[s];
      end
    end
  end

  assign out_valid = vld[RW];
  assign out_root  = root[RW];
  assign out_sb    = sb[RW];

endmodule

### rtl/rmq_div.sv
// ----------------------------------------------------------------------------
// rmq_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rmq_div #(
  parameter int NUM_W = 35,
  parameter int DEN_W = 19,
  parameter int SB_W  = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] in_den,
  input  logic [SB_W-1:0]  in_sb,
  output logic             out_valid,
  output logic [NUM_W-1:0] out_quo,
  output logic [SB_W-1:0]  out_sb
);

  logic             vld [0:NUM_W];
  logic [NUM_W-1:0] num [0:NUM_W];
  logic [DEN_W-1:0] den [0:NUM_W];
  logic [DEN_W-1:0] rem [0:NUM_W];
  logic [NUM_W-1:0] quo [0:NUM_W];
  logic [SB_W-1:0]  sb  [0:NUM_W];

  logic [DEN_W-1:0] rem_next [1:NUM_W];
  logic [NUM_W-1:0] quo_next [1:NUM_W];

  assign vld[0] = in_valid;
  assign num[0] = in_num;
  assign den[0] = in_den;
  assign rem[0] = '0;
  assign quo[0] = '0;
  assign sb[0]  = in_sb;

  // Shift in the next numerator bit and subtract the divisor if it fits.
  always_comb begin
    logic [DEN_W:0] sh;
    for (int s = 0; s < NUM_W; s++) begin
      sh = {rem[s], num[s][NUM_W-1]};
      if (sh >= {1'b0, den[s]}) begin
        rem_next[s+1] = DEN_W'(sh - {1'b0, den[s]});
        quo_next[s+1] = {quo[s][NUM_W-2:0], 1'b1};
      end else begin
        rem_next[s+1] = DEN_W'(sh);
        quo_next[s+1] = {quo[s][NUM_W-2:0], 1'b0};
      end
    end
  end

  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    // Valid bit of the stage.
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end

    // Payload of the stage.
    always_ff @(posedge clk) begin
      if (en) begin
        num[s+1] <= {num[s][NUM_W-2:0], 1'b0};
        den[s+1] <= den[s];
        rem[s+1] <= rem_next[s+1];
        quo[s+1] <= quo_next[s+1];
        sb[s+1]  <= sb[s];
      end
    end
  end

  assign out_valid = vld[NUM_W];
  assign out_quo   = quo[NUM_W];
  assign out_sb    = sb[NUM_W];

endmodule

### rtl/rotation_matrix_to_quaternion.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Converts a 3x3 rotation matrix in fixed point to a unit quaternion.
// ----------------------------------------------------------------------------
// Channel  Direction  Contents
// s_axis   in         nine matrix entries m11..m33, row-major
// m_axis   out        quaternion qx, qy, qz, qw and the invalid_input flag
//
// One transaction is accepted per cycle while the output register is free
// or being taken. The square root pipeline has RW stages, one root bit
// each, and the divider pipeline NUM_W = 19 + FRAC_BITS stages, one
// quotient bit each. Reset is synchronous and clears only the valid bits.
// While the output waits, the whole pipeline holds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rotation_matrix_to_quaternion #(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  // m11, m12, m13, m21, m22, m23, m31, m32, m33 (18 bits each), zero pad
  input  logic [167:0]  s_tdata,
  output logic          m_tvalid,
  input  logic          m_tready,
  // qx, qy, qz, qw (18 bits each)
  output logic [71:0]   m_tdata,
  // invalid_input
  output logic          m_tuser
);

  import rmq_pkg::*;

  localparam int ARG_W = ((FRAC_BITS > 18) ? FRAC_BITS : 18) + 3;
  localparam int SQ_W  = ARG_W - 1 + FRAC_BITS;
  localparam int RAD_W = SQ_W + (SQ_W % 2);
  localparam int RW    = RAD_W / 2;
  localparam int DEN_W = RW + 1;
  localparam int NUM_W = D_W + FRAC_BITS;
  localparam int HW    = RW + OUT_W;
  localparam int SB1_W = 3 + 3 * D_W;
  localparam int SB0_W = 3 + RW + 1;

  logic en;

  // The pipeline moves when the output register is free or being taken.
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Input register.
  logic                   v0;
  logic signed [IN_W-1:0] m11, m12, m13, m21, m22, m23, m31, m32, m33;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m11 <= s_tdata[17:0];
      m12 <= s_tdata[35:18];
      m13 <= s_tdata[53:36];
      m21 <= s_tdata[71:54];
      m22 <= s_tdata[89:72];
      m23 <= s_tdata[107:90];
      m31 <= s_tdata[125:108];
      m32 <= s_tdata[143:126];
      m33 <= s_tdata[161:144];
    end
  end

  // Branch choice, root argument and the three off-diagonal terms.
  logic signed [ARG_W-1:0] e11, e22, e33, one, trace, arg_c;
  logic signed [D_W-1:0]   t_c [0:2];
  slot_t                   rs_c;
  logic                    inv_c;

  always_comb begin
    e11   = ARG_W'(m11);
    e22   = ARG_W'(m22);
    e33   = ARG_W'(m33);
    one   = ARG_W'(1) << FRAC_BITS;
    trace = e11 + e22 + e33;
    if (trace > 0) begin
      rs_c   = SLOT_W;
      arg_c  = trace + one;
      t_c[0] = D_W'(m32) - D_W'(m23);
      t_c[1] = D_W'(m13) - D_W'(m31);
      t_c[2] = D_W'(m21) - D_W'(m12);
    end else if (m33 > ((m22 > m11) ? m22 : m11)) begin
      rs_c   = SLOT_Z;
      arg_c  = e33 - e11 - e22 + one;
      t_c[0] = D_W'(m13) + D_W'(m31);
      t_c[1] = D_W'(m23) + D_W'(m32);
      t_c[2] = D_W'(m21) - D_W'(m12);
    end else if (m22 > m11) begin
      rs_c   = SLOT_Y;
      arg_c  = e22 - e33 - e11 + one;
      t_c[0] = D_W'(m12) + D_W'(m21);
      t_c[1] = D_W'(m32) + D_W'(m23);
      t_c[2] = D_W'(m13) - D_W'(m31);
    end else begin
      rs_c   = SLOT_X;
      arg_c  = e11 - e22 - e33 + one;
      t_c[0] = D_W'(m21) + D_W'(m12);
      t_c[1] = D_W'(m31) + D_W'(m13);
      t_c[2] = D_W'(m32) - D_W'(m23);
    end
    inv_c = (rs_c != SLOT_W) && (arg_c <= 0);
  end

  logic                    v1, inv1;
  slot_t                   rs1;
  logic signed [ARG_W-1:0] arg1;
  logic signed [D_W-1:0]   t1 [0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inv1 <= inv_c;
      rs1  <= rs_c;
      arg1 <= arg_c;
      t1   <= t_c;
    end
  end

  // Square root of arg scaled by 2^FRAC_BITS.
  logic [RAD_W-1:0] rad;
  logic             v2;
  logic [RW-1:0]    root2;
  logic [SB1_W-1:0] sb2;

  assign rad = inv1 ? '0 : RAD_W'({arg1[ARG_W-2:0], {FRAC_BITS{1'b0}}});

  rmq_sqrt #(
    .RAD_W (RAD_W),
    .SB_W  (SB1_W)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v1),
    .in_rad    (rad),
    .in_sb     ({inv1, rs1, t1[2], t1[1], t1[0]}),
    .out_valid (v2),
    .out_root  (root2),
    .out_sb    (sb2)
  );

  // Three term dividers: |d| * 2^FRAC_BITS / (2 * root).
  logic signed [D_W-1:0] t2 [0:2];
  logic        [D_W-1:0] mag2 [0:2];
  logic        [NUM_W-1:0] quo3 [0:2];
  logic                    v3 [0:2];
  logic        [SB0_W-1:0] sb3_0;
  logic                    neg3_1, neg3_2;

  assign t2[0] = sb2[D_W-1:0];
  assign t2[1] = sb2[2*D_W-1:D_W];
  assign t2[2] = sb2[3*D_W-1:2*D_W];

  always_comb begin
    for (int n = 0; n < 3; n++) begin
      mag2[n] = t2[n][D_W-1] ? D_W'(-t2[n]) : D_W'(t2[n]);
    end
  end

  rmq_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W),
    .SB_W  (SB0_W)
  ) u_div0 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v2),
    .in_num    ({mag2[0], {FRAC_BITS{1'b0}}}),
    .in_den    ({root2, 1'b0}),
    .in_sb     ({sb2[SB1_W-1 -: 3], root2, t2[0][D_W-1]}),
    .out_valid (v3[0]),
    .out_quo   (quo3[0]),
    .out_sb    (sb3_0)
  );

  rmq_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W),
    .SB_W  (1)
  ) u_div1 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v2),
    .in_num    ({mag2[1], {FRAC_BITS{1'b0}}}),
    .in_den    ({root2, 1'b0}),
    .in_sb     (t2[1][D_W-1]),
    .out_valid (v3[1]),
    .out_quo   (quo3[1]),
    .out_sb    (neg3_1)
  );

  rmq_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W),
    .SB_W  (1)
  ) u_div2 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v2),
    .in_num    ({mag2[2], {FRAC_BITS{1'b0}}}),
    .in_den    ({root2, 1'b0}),
    .in_sb     (t2[2][D_W-1]),
    .out_valid (v3[2]),
    .out_quo   (quo3[2]),
    .out_sb    (neg3_2)
  );

  // Sign, saturation and placement of the components.
  logic              inv3;
  slot_t             rs3;
  logic [RW-1:0]     root3;
  logic              neg3 [0:2];
  logic [OUT_W-1:0]  q3 [0:2];
  logic [OUT_W-1:0]  half3;
  logic [OUT_W-1:0]  qx_c, qy_c, qz_c, qw_c;

  assign inv3    = sb3_0[SB0_W-1];
  assign rs3     = slot_t'(sb3_0[SB0_W-2 -: 2]);
  assign root3   = sb3_0[RW:1];
  assign neg3[0] = sb3_0[0];
  assign neg3[1] = neg3_1;
  assign neg3[2] = neg3_2;

  always_comb begin
    for (int n = 0; n < 3; n++) begin
      if (neg3[n]) begin
        q3[n] = (quo3[n] > NUM_W'(OUT_MIN_MAG)) ? OUT_W'(-OUT_MIN_MAG)
                                                : OUT_W'(-quo3[n]);
      end else begin
        q3[n] = (quo3[n] > NUM_W'(OUT_MAX)) ? OUT_W'(OUT_MAX) : OUT_W'(quo3[n]);
      end
    end
    half3 = (HW'(root3 >> 1) > HW'(OUT_MAX)) ? OUT_W'(OUT_MAX)
                                             : OUT_W'(HW'(root3 >> 1));
    case (rs3)
      SLOT_X: begin
        qx_c = half3; qy_c = q3[0]; qz_c = q3[1]; qw_c = q3[2];
      end
      SLOT_Y: begin
        qx_c = q3[0]; qy_c = half3; qz_c = q3[1]; qw_c = q3[2];
      end
      SLOT_Z: begin
        qx_c = q3[0]; qy_c = q3[1]; qz_c = half3; qw_c = q3[2];
      end
      default: begin
        qx_c = q3[0]; qy_c = q3[1]; qz_c = q3[2]; qw_c = half3;
      end
    endcase
    if (inv3) begin
      qx_c = '0; qy_c = '0; qz_c = '0; qw_c = '0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= v3[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {qw_c, qz_c, qy_c, qx_c};
      m_tuser <= inv3;
    end
  end

  // The dividers run in lockstep.
  `ASSERT_IMPL(a_div_lockstep, clk, rst, v3[0], v3[1] && v3[2])
  // A flagged result carries all-zero components.
  `ASSERT_IMPL(a_inv_zero, clk, rst, m_tvalid && m_tuser, m_tdata == '0)
  // The positive-trace branch never flags the root argument.
  `ASSERT_IMPL(a_inv_branch, clk, rst, v1 && inv1, rs1 != SLOT_W)
  // Reset empties the output register.
  `ASSERT_NEXT(a_rst_empty, clk, rst, !m_tvalid)

endmodule
